/* sv/rpwd_pkg.sv */
// ----------------------------------------------------------------------------
// rpwd_pkg
// Shared constants and types of the rc pwm pulse width decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rpwd_pkg;

	localparam int CHANNELS   = 6;
	localparam int COUNT_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int POS_W      = 16;
	localparam int PIN_W      = CHANNELS;
	localparam int CHAN_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CFG_IDX_W  = 2;
	localparam int EXT_W      = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd2;

	localparam logic [CFG_W-1:0] MIN_WIDTH_RST = 16'd16000;
	localparam logic [CFG_W-1:0] MAX_WIDTH_RST = 16'd32000;
	localparam logic [CFG_W-1:0] TOLERANCE_RST = 16'd1000;

	typedef struct packed {
		logic [CFG_W-1:0] min_width;
		logic [CFG_W-1:0] max_width;
		logic [CFG_W-1:0] tolerance;
	} cfg_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] position;
	} lane_res_t;

endpackage

`default_nettype wire

/* sv/rpwd_pin_if.sv */
// ----------------------------------------------------------------------------
// rpwd_pin_if
// Pin sample channel: one request carries the levels of all channel pins.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpwd_pin_if import rpwd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIN_W-1:0] pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink (input valid, input pin_levels, output ready);
endinterface

`default_nettype wire

/* sv/rpwd_res_if.sv */
// ----------------------------------------------------------------------------
// rpwd_res_if
// Result channel: one decoded pulse per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpwd_res_if import rpwd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] channel;
	logic [POS_W-1:0]  position;
	logic              last;

	modport source (output valid, output channel, output position, output last, input ready);
	modport sink (input valid, input channel, input position, input last, output ready);
endinterface

`default_nettype wire

/* sv/rpwd_lane.sv */
// ----------------------------------------------------------------------------
// rpwd_lane
// One channel: edge detect, saturating high-time counter and width qualify.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwd_lane import rpwd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire logic      level,
	input  wire cfg_t      cfg,
	output lane_res_t      res
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic                  prev_q;
	logic                  measuring_q;
	logic [COUNT_BITS-1:0] high_time_q;

	logic             rise;
	logic             fall;
	logic [EXT_W-1:0] w;
	logic [EXT_W-1:0] mn;
	logic [EXT_W-1:0] mx;
	logic [EXT_W-1:0] tol;
	logic [EXT_W-1:0] span_m1;
	logic             range_ok;
	logic             in_range;
	logic             below;
	logic             above;

	assign rise = level && !prev_q;
	assign fall = !level && prev_q;

	assign w        = EXT_W'(high_time_q);
	assign mn       = EXT_W'(cfg.min_width);
	assign mx       = EXT_W'(cfg.max_width);
	assign tol      = EXT_W'(cfg.tolerance);
	assign span_m1  = mx - mn - EXT_W'(1);
	assign range_ok = mx > mn;
	assign in_range = (w >= mn) && (w < mx);
	assign below    = (w < mn) && ((w + tol) >= mn);
	assign above    = (w >= mx) && (w < (mx + tol));

	always_comb begin
		res.hit = fall && measuring_q && range_ok && (in_range || below || above);
		if (in_range) begin
			res.position = POS_W'(w - mn);
		end else if (below) begin
			res.position = '0;
		end else begin
			res.position = POS_W'(span_m1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 1'b0;
			measuring_q <= 1'b0;
			high_time_q <= '0;
		end else if (advance) begin
			prev_q <= level;
			if (rise) begin
				measuring_q <= 1'b1;
				high_time_q <= COUNT_BITS'(1);
			end else if (level) begin
				if (measuring_q && (high_time_q != CNT_MAX)) begin
					high_time_q <= high_time_q + COUNT_BITS'(1);
				end
			end else if (prev_q) begin
				measuring_q <= 1'b0;
				high_time_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/rpwd_merge.sv */
// ----------------------------------------------------------------------------
// rpwd_merge
// Holds the lane results of one request and emits them in channel order.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwd_merge import rpwd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire lane_res_t lanes [CHANNELS],
	output logic           set_free,
	rpwd_res_if.source     res
);

	logic [CHANNELS-1:0] mask_s1;
	logic [POS_W-1:0]    pos_s1 [CHANNELS];

	logic              out_valid_q;
	logic [CHAN_W-1:0] chan_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;

	logic [CHAN_W-1:0]   sel;
	logic [CHANNELS-1:0] sel_bit;
	logic                sel_last;
	logic                move;

	always_comb begin
		sel     = '0;
		sel_bit = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (mask_s1[i]) begin
				sel     = CHAN_W'(i);
				sel_bit = CHANNELS'(1) << i;
			end
		end
	end

	assign sel_last = (mask_s1 & ~sel_bit) == '0;
	assign move     = (mask_s1 != '0) && (!out_valid_q || res.ready);
	assign set_free = (mask_s1 == '0) || (move && sel_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= '0;
		end else if (load) begin
			for (int i = 0; i < CHANNELS; i++) begin
				mask_s1[i] <= lanes[i].hit;
			end
		end else if (move) begin
			mask_s1 <= mask_s1 & ~sel_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pos_s1[i] <= lanes[i].position;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			chan_q <= sel;
			pos_q  <= pos_s1[sel];
			last_q <= sel_last;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.channel  = chan_q;
	assign res.position = pos_q;
	assign res.last     = last_q;

endmodule

`default_nettype wire

/* sv/rc_pwm_pulse_width_decoder_top.sv */
// ----------------------------------------------------------------------------
// rc_pwm_pulse_width_decoder_top
// A pulse that ends on a request passes the merge and output registers.
// Throughput: one request per cycle while the merge stage is free; a request
// ending k pulses holds it until its k results move out, one per ready cycle.
// Reset: arst_n clears pin history, counters and the merge stage and loads the
// register defaults (16000, 32000, 1000).
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pwm_pulse_width_decoder_top import rpwd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	rpwd_pin_if.sink                  pins,
	rpwd_res_if.source                results,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	cfg_t      cfg_q;
	lane_res_t lanes [CHANNELS];
	logic      set_free;
	logic      advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_width <= MIN_WIDTH_RST;
			cfg_q.max_width <= MAX_WIDTH_RST;
			cfg_q.tolerance <= TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_WIDTH: cfg_q.min_width <= cfg_data;
				REG_MAX_WIDTH: cfg_q.max_width <= cfg_data;
				REG_TOLERANCE: cfg_q.tolerance <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pins.ready = set_free;
	assign advance    = pins.valid && set_free;

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		rpwd_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.level   (pins.pin_levels[g]),
			.cfg     (cfg_q),
			.res     (lanes[g])
		);
	end

	rpwd_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.lanes    (lanes),
		.set_free (set_free),
		.res      (results)
	);

endmodule

`default_nettype wire
